// ----- design/matrix3_unit_determinant_normalize_unit_defines.svh -----
// assertion macros used by the checker file
`ifndef MATRIX3_UNIT_DETERMINANT_NORMALIZE_UNIT_DEFINES_SVH
`define MATRIX3_UNIT_DETERMINANT_NORMALIZE_UNIT_DEFINES_SVH

// same-cycle implication
`define MX3DN_ASSERT_NOW(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("mx3dn assertion failed");

// next-cycle implication
`define MX3DN_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("mx3dn assertion failed");

`endif

// ----- design/mx3dn_pkg.sv -----
// shared types and constants of the determinant normalize unit
package mx3dn_pkg;

   typedef struct packed {
      logic singular;
      logic det_neg;
   } det_flags_type;

   localparam int TERMS = 6;
   localparam int ENTRIES = 9;

   // entry indexes of the six triple products of the determinant
   localparam int TERM_IDX [TERMS][3] = '{
      '{0, 4, 8}, '{0, 5, 7}, '{1, 3, 8}, '{1, 5, 6}, '{2, 3, 7}, '{2, 4, 6}
   };

   // terms that enter with a minus sign
   localparam logic [TERMS-1:0] TERM_NEG = 6'b100110;

   localparam int QUEUE_DEPTH = 4;

endpackage

// ----- design/mx3dn_front.sv -----
// front end: magnitudes, exact determinant and normalization of its magnitude
module mx3dn_front #(
   parameter int W  = 32,
   parameter int RB = 34,
   parameter int KW = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [9*W-1:0]              in_data,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [9*W-1:0]              out_mags,
   output logic [8:0]                  out_negs,
   output mx3dn_pkg::det_flags_type    out_flags,
   output logic [KW-1:0]               out_k,
   output logic [3*RB-1:0]             out_m
);
   import mx3dn_pkg::*;

   localparam int NF = 11;
   localparam int PW = 2 * W;
   localparam int TW = 3 * W;
   localparam int DW = 3 * W + 2;
   localparam int MW = 3 * RB;
   localparam int NG = (RB + 5) / 6;

   logic [NF-1:0]        vld_ff;
   logic                 en;
   logic [9*W-1:0]       mags_ff [NF];
   logic [8:0]           negs_ff [NF];
   logic [9*W-1:0]       mags_in;
   logic [8:0]           negs_in;

   logic [PW-1:0]        p1_ff [TERMS];
   logic [TERMS-1:0]     sg1_ff, sg2_ff, sg3_in;
   logic [PW-1:0]        hi2_ff [TERMS];
   logic [PW-1:0]        lo2_ff [TERMS];
   logic signed [DW-1:0] term3_ff [TERMS];
   logic signed [DW-1:0] s4_ff [3];
   logic signed [DW-1:0] s5_ff [2];
   logic signed [DW-1:0] d6_ff;
   logic [DW-1:0]        absd_in;
   logic [MW-1:0]        m7_ff, m8_ff, m9_ff, m10_ff;
   det_flags_type        fl7_ff, fl8_ff, fl9_ff, fl10_ff;
   logic [2:0]           cnt8_ff [NG];
   logic [NG-1:0]        z8_ff;
   logic [2:0]           cnt_in [NG];
   logic [NG-1:0]        z_in;
   logic [KW-1:0]        k9_ff, k10_ff, k_in;
   logic [KW+1:0]        sh_in;

   assign en       = !vld_ff[NF-1] || out_ready;
   assign in_ready = en;

   always_comb begin
      logic [W-1:0] a;
      for (int e = 0; e < ENTRIES; e++) begin
         a = in_data[e*W +: W];
         negs_in[e] = a[W-1];
         mags_in[e*W +: W] = a[W-1] ? W'(~a + W'(1)) : a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NF-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mags_ff[0] <= mags_in;
         negs_ff[0] <= negs_in;
         for (int i = 1; i < NF; i++) begin
            mags_ff[i] <= mags_ff[i-1];
            negs_ff[i] <= negs_ff[i-1];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < TERMS; j++) begin
         sg3_in[j] = sg2_ff[j];
      end
   end

   // triple products, split so that no multiplier exceeds entry width squared
   always_ff @(posedge clock) begin
      logic [TW-1:0] prod;
      if (en) begin
         for (int j = 0; j < TERMS; j++) begin
            p1_ff[j] <= PW'(mags_ff[0][TERM_IDX[j][0]*W +: W])
                        * PW'(mags_ff[0][TERM_IDX[j][1]*W +: W]);
            sg1_ff[j] <= TERM_NEG[j] ^ negs_ff[0][TERM_IDX[j][0]]
                         ^ negs_ff[0][TERM_IDX[j][1]] ^ negs_ff[0][TERM_IDX[j][2]];
            hi2_ff[j] <= PW'(p1_ff[j][PW-1:W]) * PW'(mags_ff[1][TERM_IDX[j][2]*W +: W]);
            lo2_ff[j] <= PW'(p1_ff[j][W-1:0]) * PW'(mags_ff[1][TERM_IDX[j][2]*W +: W]);
            prod = {hi2_ff[j], {W{1'b0}}} + TW'(lo2_ff[j]);
            term3_ff[j] <= sg3_in[j] ? -DW'(prod) : DW'(prod);
         end
         sg2_ff   <= sg1_ff;
         s4_ff[0] <= term3_ff[0] + term3_ff[1];
         s4_ff[1] <= term3_ff[2] + term3_ff[3];
         s4_ff[2] <= term3_ff[4] + term3_ff[5];
         s5_ff[0] <= s4_ff[0] + s4_ff[1];
         s5_ff[1] <= s4_ff[2];
         d6_ff    <= s5_ff[0] + s5_ff[1];
      end
   end

   assign absd_in = d6_ff[DW-1] ? DW'(-d6_ff) : DW'(d6_ff);

   // leading zero 3-bit digits, six digits per group
   always_comb begin
      logic run;
      int   d;
      for (int g = 0; g < NG; g++) begin
         run = 1'b1;
         cnt_in[g] = '0;
         for (int j = 0; j < 6; j++) begin
            d = g * 6 + j;
            if (d < RB && run && m7_ff[MW-1-3*d -: 3] == 3'b000) begin
               cnt_in[g] = cnt_in[g] + 3'd1;
            end else begin
               run = 1'b0;
            end
         end
         z_in[g] = run;
      end
   end

   always_comb begin
      logic run;
      run  = 1'b1;
      k_in = '0;
      for (int g = 0; g < NG; g++) begin
         if (run) begin
            k_in = k_in + KW'(cnt8_ff[g]);
         end
         if (!z8_ff[g]) begin
            run = 1'b0;
         end
      end
   end

   assign sh_in = {k9_ff, 1'b0} + (KW+2)'(k9_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         m7_ff            <= MW'(absd_in);
         fl7_ff.det_neg   <= d6_ff[DW-1];
         fl7_ff.singular  <= (d6_ff == '0);
         m8_ff            <= m7_ff;
         fl8_ff           <= fl7_ff;
         cnt8_ff          <= cnt_in;
         z8_ff            <= z_in;
         m9_ff            <= m8_ff;
         fl9_ff           <= fl8_ff;
         k9_ff            <= k_in;
         m10_ff           <= m9_ff << sh_in;
         fl10_ff          <= fl9_ff;
         k10_ff           <= k9_ff;
      end
   end

   assign out_valid = vld_ff[NF-1];
   assign out_mags  = mags_ff[NF-1];
   assign out_negs  = negs_ff[NF-1];
   assign out_flags = fl10_ff;
   assign out_k     = k10_ff;
   assign out_m     = m10_ff;

endmodule

// ----- design/mx3dn_queue.sv -----
// small first-in first-out queue between front and back end
module mx3dn_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [AW:0]      cnt_ff;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + (AW+1)'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - (AW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ----- design/mx3dn_root.sv -----
// pipelined cube root, one 3-bit digit per stage
module mx3dn_root #(
   parameter int RB   = 34,
   parameter int PAYW = 8
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            in_valid,
   input  logic [3*RB-1:0] in_m,
   input  logic [PAYW-1:0] in_pay,
   output logic            out_valid,
   output logic [RB-1:0]   out_r,
   output logic [PAYW-1:0] out_pay
);
   localparam int MW = 3 * RB;
   localparam int SW = 2 * RB;
   localparam int RW = 2 * RB + 2;
   localparam int RX = RW + 3;

   logic [RB-1:0]   vld_ff;
   logic [RB-1:0]   r_ff   [RB];
   logic [SW-1:0]   s_ff   [RB];
   logic [RW-1:0]   rem_ff [RB];
   logic [MW-1:0]   m_ff   [RB];
   logic [PAYW-1:0] pay_ff [RB];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[RB-2:0], in_valid};
      end
   end

   for (genvar i = 0; i < RB; i++) begin : g_stage
      logic [RB-1:0]   rp;
      logic [SW-1:0]   sp;
      logic [RW-1:0]   remp;
      logic [MW-1:0]   mp;
      logic [PAYW-1:0] payp;
      logic [RX-1:0]   remx, t;
      logic            ge;

      if (i == 0) begin : g_first
         assign rp   = '0;
         assign sp   = '0;
         assign remp = '0;
         assign mp   = in_m;
         assign payp = in_pay;
      end else begin : g_next
         assign rp   = r_ff[i-1];
         assign sp   = s_ff[i-1];
         assign remp = rem_ff[i-1];
         assign mp   = m_ff[i-1];
         assign payp = pay_ff[i-1];
      end

      // (2r+1)^3 - (2r)^3 = 12r^2 + 6r + 1
      always_comb begin
         remx = {remp, mp[MW-1 -: 3]};
         t    = RX'({sp, 3'b000}) + RX'({sp, 2'b00}) + RX'({rp, 2'b00})
                + RX'({rp, 1'b0}) + RX'(1);
         ge   = (remx >= t);
      end

      always_ff @(posedge clock) begin
         if (en) begin
            r_ff[i]   <= {rp[RB-2:0], ge};
            s_ff[i]   <= ge ? SW'({sp, 2'b00}) + SW'({rp, 2'b00}) + SW'(1)
                            : SW'({sp, 2'b00});
            rem_ff[i] <= ge ? RW'(remx - t) : RW'(remx);
            m_ff[i]   <= mp << 3;
            pay_ff[i] <= payp;
         end
      end
   end

   assign out_valid = vld_ff[RB-1];
   assign out_r     = r_ff[RB-1];
   assign out_pay   = pay_ff[RB-1];

endmodule

// ----- design/mx3dn_div.sv -----
// rounded scaling of the nine entries by the root, bit-per-stage division
module mx3dn_div #(
   parameter int W  = 32,
   parameter int F  = 16,
   parameter int RB = 34,
   parameter int KW = 6
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [RB-1:0]            in_r,
   input  logic [9*W-1:0]           in_mags,
   input  logic [8:0]               in_negs,
   input  mx3dn_pkg::det_flags_type in_flags,
   input  logic [KW-1:0]            in_k,
   output logic                     out_valid,
   output logic [9*W-1:0]           out_h,
   output logic                     out_status
);
   import mx3dn_pkg::*;

   localparam int NW = W + F + RB;
   localparam int HW = NW - W;
   localparam int NV = W + 3;

   logic [NV-1:0]   vld_ff;
   logic [NW-1:0]   n0_ff [ENTRIES];
   logic [8:0]      neg0_ff, neg1_ff;
   logic            sing0_ff, sing1_ff;
   logic [RB-1:0]   r0_ff, r1_ff;
   logic [RB-1:0]   rem1_ff [ENTRIES];
   logic [W-1:0]    lo1_ff [ENTRIES];
   logic [8:0]      sat1_ff;

   logic [RB-1:0]   rem_ff [W][ENTRIES];
   logic [W-1:0]    lo_ff  [W][ENTRIES];
   logic [8:0]      sat_ff [W];
   logic [8:0]      neg_ff [W];
   logic            sing_ff [W];
   logic [RB-1:0]   r_ff [W];

   logic [9*W-1:0]  h_ff, h_in;
   logic            st_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NV-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [HW-1:0] hi;
      if (en) begin
         for (int e = 0; e < ENTRIES; e++) begin
            n0_ff[e] <= (NW'(in_mags[e*W +: W]) << (F + int'(in_k))) + NW'(in_r >> 1);
            hi = n0_ff[e][NW-1:W];
            sat1_ff[e] <= (hi >= HW'(r0_ff));
            rem1_ff[e] <= hi[RB-1:0];
            lo1_ff[e]  <= n0_ff[e][W-1:0];
         end
         neg0_ff  <= in_negs ^ {9{in_flags.det_neg}};
         sing0_ff <= in_flags.singular;
         r0_ff    <= in_r;
         neg1_ff  <= neg0_ff;
         sing1_ff <= sing0_ff;
         r1_ff    <= r0_ff;
      end
   end

   for (genvar j = 0; j < W; j++) begin : g_stage
      logic [RB-1:0] remp [ENTRIES];
      logic [W-1:0]  lop  [ENTRIES];
      logic [8:0]    satp, negp;
      logic          singp;
      logic [RB-1:0] rp;

      if (j == 0) begin : g_first
         assign remp  = rem1_ff;
         assign lop   = lo1_ff;
         assign satp  = sat1_ff;
         assign negp  = neg1_ff;
         assign singp = sing1_ff;
         assign rp    = r1_ff;
      end else begin : g_next
         assign remp  = rem_ff[j-1];
         assign lop   = lo_ff[j-1];
         assign satp  = sat_ff[j-1];
         assign negp  = neg_ff[j-1];
         assign singp = sing_ff[j-1];
         assign rp    = r_ff[j-1];
      end

      always_ff @(posedge clock) begin
         logic [RB:0] remx;
         logic        ge;
         if (en) begin
            for (int e = 0; e < ENTRIES; e++) begin
               remx = {remp[e], lop[e][W-1]};
               ge   = (remx >= {1'b0, rp});
               rem_ff[j][e] <= ge ? RB'(remx - {1'b0, rp}) : RB'(remx);
               lo_ff[j][e]  <= {lop[e][W-2:0], ge};
            end
            sat_ff[j]  <= satp;
            neg_ff[j]  <= negp;
            sing_ff[j] <= singp;
            r_ff[j]    <= rp;
         end
      end
   end

   // saturate, apply sign, clear for a singular matrix
   always_comb begin
      logic [W-1:0] q, v;
      logic         psat, nsat;
      for (int e = 0; e < ENTRIES; e++) begin
         q    = lo_ff[W-1][e];
         psat = sat_ff[W-1][e] || q[W-1];
         nsat = sat_ff[W-1][e] || (q[W-1] && (|q[W-2:0]));
         if (neg_ff[W-1][e]) begin
            v = nsat ? {1'b1, {(W-1){1'b0}}} : q;
            v = W'(-v);
         end else begin
            v = psat ? {1'b0, {(W-1){1'b1}}} : q;
         end
         h_in[e*W +: W] = sing_ff[W-1] ? '0 : v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_ff  <= h_in;
         st_ff <= sing_ff[W-1];
      end
   end

   assign out_valid  = vld_ff[NV-1];
   assign out_h      = h_ff;
   assign out_status = st_ff;

endmodule

// ----- design/matrix3_unit_determinant_normalize_unit.sv -----
// top level of the 3x3 determinant normalize unit
//
// Takes one 3x3 matrix of signed fixed-point entries per request and returns
// the matrix divided by the real cube root of its determinant, rounded half
// away from zero and saturated, so that the result has determinant one. A
// zero determinant returns all-zero entries with rsp_tuser set. Fully
// pipelined: one matrix per clock sustained while rsp_tready stays high.
// The pipeline length is set by the cube root, which resolves one 3-bit
// digit per stage over ENTRY_WIDTH+2 stages, and by the scaling divider,
// one quotient bit per stage over ENTRY_WIDTH stages. A four-entry queue
// between the determinant front end and the root/divide back end keeps
// requests flowing while a response waits.
module matrix3_unit_determinant_normalize_unit #(
   parameter int ENTRY_WIDTH = 32,
   parameter int FRAC_BITS   = 16,
   localparam int DATA_W     = ((9 * ENTRY_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // a_r0c0 .. a_r2c2, zero pad
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // h_r0c0 .. h_r2c2, zero pad
   output logic [0:0]        rsp_tuser    // status
);
   import mx3dn_pkg::*;

   localparam int W    = ENTRY_WIDTH;
   localparam int RB   = W + 2;
   localparam int KW   = $clog2(RB);
   localparam int FLW  = $bits(det_flags_type);
   localparam int PAYW = 9 * W + 9 + FLW + KW;
   localparam int QW   = PAYW + 3 * RB;

   logic              f_valid, q_full, q_empty, q_pop, en_b;
   logic [9*W-1:0]    f_mags;
   logic [8:0]        f_negs;
   det_flags_type     f_flags;
   logic [KW-1:0]     f_k;
   logic [3*RB-1:0]   f_m;
   logic [QW-1:0]     q_rdata;
   logic              r_valid;
   logic [RB-1:0]     r_root;
   logic [PAYW-1:0]   r_pay;
   logic [9*W-1:0]    d_h;
   logic              d_status;

   mx3dn_front #(.W(W), .RB(RB), .KW(KW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata[9*W-1:0]),
      .out_valid (f_valid),
      .out_ready (!q_full),
      .out_mags  (f_mags),
      .out_negs  (f_negs),
      .out_flags (f_flags),
      .out_k     (f_k),
      .out_m     (f_m)
   );

   mx3dn_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (f_valid && !q_full),
      .wdata ({f_m, f_k, f_flags, f_negs, f_mags}),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign en_b  = !rsp_tvalid || rsp_tready;
   assign q_pop = en_b && !q_empty;

   mx3dn_root #(.RB(RB), .PAYW(PAYW)) u_root (
      .clock     (clock),
      .reset     (reset),
      .en        (en_b),
      .in_valid  (!q_empty),
      .in_m      (q_rdata[QW-1 -: 3*RB]),
      .in_pay    (q_rdata[PAYW-1:0]),
      .out_valid (r_valid),
      .out_r     (r_root),
      .out_pay   (r_pay)
   );

   mx3dn_div #(.W(W), .F(FRAC_BITS), .RB(RB), .KW(KW)) u_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en_b),
      .in_valid   (r_valid),
      .in_r       (r_root),
      .in_mags    (r_pay[9*W-1:0]),
      .in_negs    (r_pay[9*W +: 9]),
      .in_flags   (det_flags_type'(r_pay[9*W+9 +: FLW])),
      .in_k       (r_pay[PAYW-1 -: KW]),
      .out_valid  (rsp_tvalid),
      .out_h      (d_h),
      .out_status (d_status)
   );

   assign rsp_tdata = DATA_W'(d_h);
   assign rsp_tuser = d_status;

endmodule

// ----- design/mx3dn_checker.sv -----
// port-level checks of the determinant normalize unit, bound to the top level
`include "matrix3_unit_determinant_normalize_unit_defines.svh"

module mx3dn_checker #(
   parameter int ENTRY_WIDTH = 32,
   localparam int DATA_W     = ((9 * ENTRY_WIDTH + 7) / 8) * 8
) (
   input logic              clock,
   input logic              reset,
   input logic              req_tvalid,
   input logic              req_tready,
   input logic [DATA_W-1:0] req_tdata,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [DATA_W-1:0] rsp_tdata,
   input logic [0:0]        rsp_tuser
);

   `MX3DN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
   `MX3DN_ASSERT_NOW(a_singular_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0)
   `MX3DN_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `MX3DN_ASSERT_NOW(a_known_ready, clock, reset, req_tvalid, !$isunknown(req_tready) && !$isunknown(req_tdata))

endmodule

bind matrix3_unit_determinant_normalize_unit mx3dn_checker #(.ENTRY_WIDTH(ENTRY_WIDTH)) u_mx3dn_checker (.*);

// ----- bench/tb.sv -----
// testbench of the 3x3 determinant normalize unit with a self-checking predictor
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EW = 32;
   localparam int FB = 16;
   localparam int RB = EW + 2;
   localparam int DW = 9 * EW;
   localparam int LATENCY = 2 * EW + 17;
   localparam int WATCH_LIMIT = 20000;

   typedef logic signed [EW-1:0] entry_type;
   typedef entry_type mat_type [9];
   typedef struct {
      logic [DW-1:0] data;
      logic          singular;
   } norm_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;   // a_r0c0 .. a_r2c2
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [DW-1:0] rsp_tdata;        // h_r0c0 .. h_r2c2
   logic [0:0]    rsp_tuser;        // status

   norm_result_type expected_norms [$];
   int              errors = 0;
   bit              idle_on = 1'b1;
   bit              hold_off = 1'b0;
   int              quiet_cycles = 0;
   int              rsp_idle_left = 0;

   matrix3_unit_determinant_normalize_unit #(.ENTRY_WIDTH(EW), .FRAC_BITS(FB)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic norm_result_type normalize_matrix(mat_type a);
      norm_result_type res;
      logic [EW:0]     mag [9];
      bit              neg [9];
      logic [255:0]    pos, ngs, m, cube, t;
      logic [127:0]    q;
      logic [63:0]     root, cand, qv;
      int              k, nb, idx [6][3];
      bit              tneg [6], dneg, s;
      idx = '{'{0,4,8}, '{0,5,7}, '{1,3,8}, '{1,5,6}, '{2,3,7}, '{2,4,6}};
      tneg = '{0, 1, 1, 0, 0, 1};
      res.data = '0;
      res.singular = 1'b0;
      for (int i = 0; i < 9; i++) begin
         neg[i] = a[i][EW-1];
         mag[i] = neg[i] ? -$signed({a[i][EW-1], a[i]}) : {1'b0, a[i]};
      end
      pos = '0;
      ngs = '0;
      for (int i = 0; i < 6; i++) begin
         s = tneg[i] ^ neg[idx[i][0]] ^ neg[idx[i][1]] ^ neg[idx[i][2]];
         t = 256'(mag[idx[i][0]]) * 256'(mag[idx[i][1]]) * 256'(mag[idx[i][2]]);
         if (s) ngs = ngs + t;
         else pos = pos + t;
      end
      if (pos == ngs) begin
         res.singular = 1'b1;
         return res;
      end
      dneg = pos < ngs;
      m = dneg ? ngs - pos : pos - ngs;
      nb = 0;
      for (int b = 0; b < 256; b++) if (m[b]) nb = b + 1;
      k = (3 * RB - nb) / 3;
      m = m << (3 * k);
      root = '0;
      for (int b = RB - 1; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         cube = 256'(cand) * 256'(cand) * 256'(cand);
         if (cube <= m) root = cand;
      end
      for (int i = 0; i < 9; i++) begin
         t = (256'(mag[i]) << (FB + k)) + 256'(root >> 1);
         q = 128'(t / 256'(root));
         qv = (q[127:64] != 0) ? '1 : q[63:0];
         if (neg[i] ^ dneg) begin
            if (qv > (64'd1 << (EW - 1))) qv = 64'd1 << (EW - 1);
            res.data[i*EW +: EW] = -qv[EW-1:0];
         end else begin
            if (qv > (64'd1 << (EW - 1)) - 1) qv = (64'd1 << (EW - 1)) - 1;
            res.data[i*EW +: EW] = qv[EW-1:0];
         end
      end
      return res;
   endfunction

   task automatic send_matrix(mat_type a);
      logic [DW-1:0] d;
      for (int i = 0; i < 9; i++) d[i*EW +: EW] = a[i];
      req_tvalid <= 1'b1;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      expected_norms.push_back(normalize_matrix(a));
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   function automatic entry_type random_entry();
      case ($urandom_range(0, 5))
         0: return entry_type'($urandom);
         1: return entry_type'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
         2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         3: return 0;
         4: return $urandom_range(0, 1) ? 32'sh10000 : -32'sh10000;
         default: return entry_type'($signed($urandom_range(0, 32'hffffff)) - 32'sh7fffff);
      endcase
   endfunction

   function automatic mat_type random_matrix();
      mat_type a;
      for (int i = 0; i < 9; i++) a[i] = random_entry();
      if ($urandom_range(0, 7) == 0)
         for (int i = 0; i < 3; i++) a[6 + i] = a[i];
      return a;
   endfunction

   // receiver readiness with random idle bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_idle_left <= 0;
      end else if (hold_off) begin
         rsp_tready <= 1'b0;
      end else if (rsp_idle_left > 0) begin
         rsp_tready <= 1'b0;
         rsp_idle_left <= rsp_idle_left - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rsp_idle_left <= $urandom_range(0, 18);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_norms.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            errors++;
         end else begin
            norm_result_type e;
            e = expected_norms.pop_front();
            for (int i = 0; i < 9; i++)
               if (rsp_tdata[i*EW +: EW] !== e.data[i*EW +: EW]) begin
                  $error("h_r%0dc%0d expected %h actual %h", i / 3, i % 3,
                         e.data[i*EW +: EW], rsp_tdata[i*EW +: EW]);
                  errors++;
               end
            if (rsp_tuser[0] !== e.singular) begin
               $error("status expected %b actual %b", e.singular, rsp_tuser[0]);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic test_directed();
      mat_type a;
      a = '{32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
      send_matrix(a);
      a = '{32'sh20000, 0, 0, 0, 32'sh20000, 0, 0, 0, 32'sh20000};
      send_matrix(a);
      a = '{-32'sh10000, 0, 0, 0, 32'sh10000, 0, 0, 0, 32'sh10000};
      send_matrix(a);
      a = '{default: 0};
      send_matrix(a);
      a = '{default: 32'sh7fffffff};
      send_matrix(a);
      a = '{32'sh80000000, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh80000000};
      send_matrix(a);
      a = '{32'sh7fffffff, 0, 0, 0, 32'sh80000000, 0, 0, 0, 32'sh7fffffff};
      send_matrix(a);
      a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(a);
      a = '{32'sh7fffffff, 0, 0, 0, 1, 0, 0, 0, 1};
      send_matrix(a);
      a = '{32'sh10000, 32'sh20000, 32'sh30000, 32'sh40000, 32'sh50000, 32'sh60000,
            32'sh70000, 32'sh80000, 32'sha0000};
      send_matrix(a);
      a = '{-1, 32'h5555aaaa, 32'haaaa5555, 32'h0f0f0f0f, -2, 32'hf0f0f0f0,
            32'h12345678, 32'h87654321, 32'h7fff0001};
      send_matrix(a);
      a = '{0, 32'sh10000, 0, 0, 0, 32'sh10000, 32'sh10000, 0, 0};
      send_matrix(a);
   endtask

   task automatic test_random(int n);
      repeat (n) send_matrix(random_matrix());
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         test_random(40);
         begin
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
      join
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(500);
      test_backpressure();
      idle_on = 1'b0;
      test_random(200);
      req_tvalid <= 1'b0;
      while (expected_norms.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (errors == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule
